[rtl/ptsp_pkg.sv]
// Shared types and constants for the planar tile sprite plotter.
// Used by ptsp_front, ptsp_back and the top level; depends on nothing.
package ptsp_pkg;

  localparam logic [3:0] BLEND_SEE_A = 4'h5;
  localparam logic [3:0] BLEND_SEE_B = 4'ha;
  localparam logic [3:0] BLEND_SEE_C = 4'hf;

  localparam logic [1:0] MODE_PLOT   = 2'd0;
  localparam logic [1:0] MODE_SPRITE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_ACK    = 2'd3;

  localparam int IN_BITS  = 192;
  localparam int OUT_BITS = 16;

  typedef enum logic [1:0] {
    KIND_DRAW = 2'd0,
    KIND_READ = 2'd1,
    KIND_ACK  = 2'd2
  } kind_t;

  // One classified command waiting for the back end
  typedef struct packed {
    kind_t        kind;
    logic         layer;
    logic         single;
    logic [15:0]  x;
    logic [15:0]  y;
    logic [63:0]  d0;
    logic [63:0]  d1;
    logic [63:0]  en;
    logic [14:0]  ridx;
  } entry_t;

  // Back end status seen by the front end
  typedef struct packed {
    logic take;
    logic clearing;
  } back_stat_t;

endpackage

[rtl/ptsp_front.sv]
// Front end: accepts input words, classifies them into draw, read and
// acknowledge entries and holds them in a two-entry queue. Uses ptsp_pkg.
module ptsp_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [191:0]               s_tdata,
  input  ptsp_pkg::back_stat_t       stat,
  output logic                       q_valid,
  output ptsp_pkg::entry_t           q_head
);
  import ptsp_pkg::*;

  logic [1:0]  mode;
  logic [15:0] px;
  logic [15:0] py;
  logic [7:0]  cmd;
  logic [63:0] pl;
  logic [63:0] ph;
  logic        rlayer;
  logic [3:0]  upper;
  logic [3:0]  lower;
  logic        p0bit;
  logic        p1bit;
  logic        two;
  logic        see;
  entry_t      ent;

  entry_t      q [2];
  logic        wp;
  logic        rp;
  logic [1:0]  count;
  logic        push;

  // Unpack the input word
  assign mode   = s_tdata[1:0];
  assign px     = s_tdata[17:2];
  assign py     = s_tdata[33:18];
  assign cmd    = s_tdata[41:34];
  assign pl     = s_tdata[105:42];
  assign ph     = s_tdata[169:106];
  assign rlayer = s_tdata[170];
  assign upper  = cmd[7:4];
  assign lower  = cmd[3:0];

  assign p0bit = !(lower == 4'd0 || lower == 4'd2);
  assign p1bit = !(lower == 4'd0 || lower == 4'd1);
  assign two   = (upper[3:1] != 3'd0);
  assign see   = (lower == BLEND_SEE_A) || (lower == BLEND_SEE_B) || (lower == BLEND_SEE_C);

  // Classify into a queue entry with per-pixel data and enables
  always_comb begin
    ent        = '0;
    ent.x      = px;
    ent.y      = py;
    ent.ridx   = s_tdata[185:171];
    case (mode)
      MODE_PLOT: begin
        ent.kind   = KIND_DRAW;
        ent.layer  = (upper != 4'd0);
        ent.single = 1'b1;
        ent.d0     = {p0bit, 63'd0};
        ent.d1     = {p1bit, 63'd0};
        ent.en     = {1'b1, 63'd0};
      end
      MODE_SPRITE: begin
        ent.kind   = KIND_DRAW;
        ent.layer  = upper[0];
        ent.single = 1'b0;
        if (two) begin
          ent.d0 = pl;
          ent.d1 = ph;
          ent.en = {64{1'b1}};
        end else begin
          ent.d0 = (pl & {64{lower[0]}}) | (~pl & {64{lower[2]}});
          ent.d1 = (pl & {64{lower[1]}}) | (~pl & {64{lower[3]}});
          ent.en = see ? pl : {64{1'b1}};
        end
      end
      MODE_READ: begin
        ent.kind  = KIND_READ;
        ent.layer = rlayer;
      end
      default: begin
        ent.kind = KIND_ACK;
      end
    endcase
  end

  assign s_tready = (count != 2'd2) && !stat.clearing;
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_head   = q[rp];

  // Hold entries until the back end takes them
  always_ff @(posedge clk) begin
    if (push) q[wp] <= ent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (stat.take) rp <= ~rp;
      case ({push, stat.take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/ptsp_back.sv]
// Back end: layer memories, reset clearing sweep, read-modify-write
// sequencer for draws, byte reads and the result register. Uses ptsp_pkg.
module ptsp_back #(
  parameter int TILES_ACROSS = 48,
  parameter int TILES_DOWN   = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  ptsp_pkg::entry_t           q_head,
  output ptsp_pkg::back_stat_t       stat,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [15:0]                m_tdata
);
  import ptsp_pkg::*;

  localparam int WORDS = TILES_ACROSS * TILES_DOWN * 8;
  localparam int AW    = $clog2(WORDS);
  localparam logic [15:0] ROWS  = 16'(TILES_DOWN * 8);
  localparam logic [12:0] COLS  = 13'(TILES_ACROSS);
  localparam logic [31:0] BYTES = 32'(WORDS * 2);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_STEP   = 6'b000100,
    S_WR     = 6'b001000,
    S_RDWAIT = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t      state;
  state_t      state_next;
  entry_t      cur;
  logic [2:0]  v;
  logic        g;
  logic [AW-1:0] clr;
  logic        dirty;
  logic [7:0]  res;

  logic [15:0] bg_mem [WORDS];
  logic [15:0] fg_mem [WORDS];
  logic [15:0] bg_q;
  logic [15:0] fg_q;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [15:0] wdata;
  logic        we_bg;
  logic        we_fg;

  logic [7:0]  d0r;
  logic [7:0]  d1r;
  logic [7:0]  enr;
  logic [15:0] w0;
  logic [15:0] w1;
  logic [15:0] wm;
  logic [7:0]  s_d0;
  logic [7:0]  s_d1;
  logic [7:0]  s_m;
  logic [15:0] yy;
  logic [12:0] cb;
  logic        onscr;
  logic [31:0] word32;
  logic [AW-1:0] step_addr;
  logic [31:0] rword32;
  logic [AW-1:0] s_addr;
  logic [7:0]  n0;
  logic [7:0]  n1;
  logic [7:0]  nm;
  logic [15:0] old;
  logic        last;
  logic        rok;
  logic [15:0] rq;

  // Select the sprite row and align it to the two touched tile columns
  assign d0r = cur.d0[{~v, 3'b000} +: 8];
  assign d1r = cur.d1[{~v, 3'b000} +: 8];
  assign enr = cur.en[{~v, 3'b000} +: 8];
  assign w0  = {d0r, 8'h00} >> cur.x[2:0];
  assign w1  = {d1r, 8'h00} >> cur.x[2:0];
  assign wm  = {enr, 8'h00} >> cur.x[2:0];
  assign s_d0 = g ? w0[7:0] : w0[15:8];
  assign s_d1 = g ? w1[7:0] : w1[15:8];
  assign s_m  = g ? wm[7:0] : wm[15:8];

  // Locate the word for this row and tile column
  assign yy     = cur.y + {13'd0, v};
  assign cb     = cur.x[15:3] + {12'd0, g};
  assign onscr  = (yy < ROWS) && (cb < COLS);
  assign word32 = (({19'd0, yy[15:3]} * 32'(TILES_ACROSS) + {19'd0, cb}) << 3)
                  | {29'd0, yy[2:0]};
  assign step_addr = word32[AW-1:0];

  // Read word address and range check for byte reads
  assign rword32 = {18'd0, q_head.ridx[14:4], q_head.ridx[2:0]};
  assign rok     = ({17'd0, cur.ridx} < BYTES);
  assign rq      = cur.layer ? fg_q : bg_q;

  assign last = g && ((v == 3'd7) || cur.single);
  assign old  = cur.layer ? fg_q : bg_q;

  assign stat.take     = (state == S_IDLE) && q_valid;
  assign stat.clearing = (state == S_CLEAR);

  // Drive memory ports
  always_comb begin
    raddr = step_addr;
    if (state == S_IDLE) raddr = rword32[AW-1:0];
    if (state == S_CLEAR) begin
      waddr = clr;
      wdata = 16'd0;
      we_bg = 1'b1;
      we_fg = 1'b1;
    end else begin
      waddr = s_addr;
      wdata = {(old[15:8] & ~nm) | (n1 & nm), (old[7:0] & ~nm) | (n0 & nm)};
      we_bg = (state == S_WR) && !cur.layer;
      we_fg = (state == S_WR) && cur.layer;
    end
  end

  always_ff @(posedge clk) begin
    if (we_bg) bg_mem[waddr] <= wdata;
    bg_q <= bg_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (we_fg) fg_mem[waddr] <= wdata;
    fg_q <= fg_mem[raddr];
  end

  // Sequence next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (clr == AW'(WORDS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (q_valid) begin
          case (q_head.kind)
            KIND_DRAW: state_next = S_STEP;
            KIND_READ: state_next = S_RDWAIT;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_STEP: begin
        if (onscr && (s_m != 8'd0)) state_next = S_WR;
        else if (last) state_next = S_DONE;
      end
      S_WR:     state_next = last ? S_DONE : S_STEP;
      S_RDWAIT: state_next = S_DONE;
      S_DONE:   if (!m_tvalid || m_tready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Latch the current entry and step data
  always_ff @(posedge clk) begin
    if (stat.take) cur <= q_head;
    if (state == S_STEP) begin
      s_addr <= step_addr;
      n0     <= s_d0;
      n1     <= s_d1;
      nm     <= s_m;
    end
    if (state == S_IDLE) res <= 8'd0;
    if (state == S_RDWAIT) begin
      if (rok) res <= cur.ridx[3] ? rq[15:8] : rq[7:0];
      else     res <= 8'd0;
    end
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {7'd0, (cur.kind == KIND_DRAW) ? 1'b1 :
                        (cur.kind == KIND_ACK) ? 1'b0 : dirty, res};
    end
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      v        <= 3'd0;
      g        <= 1'b0;
      dirty    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr <= clr + AW'(1);
      if (state == S_IDLE) begin
        v <= 3'd0;
        g <= 1'b0;
      end
      if ((state == S_STEP && state_next != S_WR) || state == S_WR) begin
        g <= ~g;
        if (g) v <= v + 3'd1;
      end
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        if (cur.kind == KIND_DRAW) dirty <= 1'b1;
        else if (cur.kind == KIND_ACK) dirty <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[rtl/planar_tile_sprite_plotter_unit.sv]
// Planar tile sprite plotter: one word in, one result word out per command.
// The back end sequencer takes one command at a time; for a draw it steps
// through each row and tile column it covers in turn, adding a write step
// for each one that is written.
// Reset: synchronous; a sweep over all TILES_ACROSS*TILES_DOWN*8 words clears
// both layer stores, during which no input word is accepted.
module planar_tile_sprite_plotter_unit #(
  parameter int TILES_ACROSS = 48,
  parameter int TILES_DOWN   = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // mode[1:0], pos_x[17:2], pos_y[33:18], command[41:34],
  // sprite_plane_low[105:42], sprite_plane_high[169:106],
  // read_layer[170], read_index[185:171], zero pad
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // read_data[7:0], redraw_pending[8], zero pad
  output logic [15:0]  m_tdata
);
  import ptsp_pkg::*;

  back_stat_t stat;
  logic       q_valid;
  entry_t     q_head;

  ptsp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .stat     (stat),
    .q_valid  (q_valid),
    .q_head   (q_head)
  );

  ptsp_back #(
    .TILES_ACROSS (TILES_ACROSS),
    .TILES_DOWN   (TILES_DOWN)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
